// File: rtl/pbt_pkg.sv
package pbt_pkg;

    localparam logic [1:0] KIND_TONE_REG  = 2'd0;
    localparam logic [1:0] KIND_OTHER_REG = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW  = 2'd2;

    localparam logic [1:0] EV_START  = 2'd0;
    localparam logic [1:0] EV_STOP   = 2'd1;
    localparam logic [1:0] EV_UPDATE = 2'd2;

    localparam logic CFG_BUZZER_EN = 1'b0;
    localparam logic CFG_FREQ_RESP = 1'b1;

    localparam int         RESP_COUNT   = 31;
    localparam logic [8:0] RESP_BASE    = 9'h0e0;
    localparam logic [8:0] RESP_TOP     = 9'h0fe;
    localparam logic [6:0] RESP_DEFAULT = 7'd30;
    localparam logic [6:0] RESP_FULL    = 7'd72;
    localparam logic [8:0] PERIOD_FULL  = 9'd256;
    localparam logic [8:0] STOP_PERIOD  = 9'd255;
    localparam logic [7:0] STOP_PULSE   = 8'd255;

    localparam logic [6:0] RESP_TABLE [RESP_COUNT] = '{
        7'd62, 7'd62, 7'd62, 7'd62, 7'd62, 7'd62, 7'd62, 7'd63,
        7'd63, 7'd64, 7'd63, 7'd63, 7'd63, 7'd64, 7'd64, 7'd64,
        7'd66, 7'd65, 7'd66, 7'd64, 7'd64, 7'd64, 7'd64, 7'd65,
        7'd66, 7'd69, 7'd71, 7'd72, 7'd70, 7'd69, 7'd66
    };

    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][1:0] codes;
        logic [8:0]      period;
        logic [7:0]      pulse;
        logic [6:0]      gain;
    } t_job;

    function automatic logic [6:0] gain_of(input logic resp_en, input logic [8:0] period);
        logic [8:0] offs;
        offs = period - RESP_BASE;
        if (!resp_en) begin
            return RESP_FULL;
        end else if (period < RESP_BASE || period > RESP_TOP) begin
            return RESP_DEFAULT;
        end else begin
            return RESP_TABLE[offs[4:0]];
        end
    endfunction

endpackage

// File: rtl/pbt_front.sv
module pbt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_index,
    input  logic          i_cfg_data,
    input  logic          i_take,
    input  logic [1:0]    i_kind,
    input  logic [7:0]    i_reload_value,
    input  logic [7:0]    i_compare_value,
    input  logic          i_timer_low_running,
    input  logic          i_compare_reload_enable,
    input  logic          i_long_mode,
    input  logic          i_port_output_dir,
    input  logic          i_port_pwm_function,
    input  logic          i_port_latch_high,
    output logic          o_push,
    output pbt_pkg::t_job o_job
);
    import pbt_pkg::*;

    logic       r_buzzer_en, r_resp_en;
    logic [7:0] r_reload, r_compare, n_reload, n_compare;
    logic [8:0] r_period, n_period;
    logic [7:0] r_pulse, n_pulse;
    logic       r_active, n_active;

    logic            configured, do_set, do_play, flat;
    logic [8:0]      sp;
    logic [7:0]      sq;
    logic [1:0]      cnt;
    logic [2:0][1:0] codes;

    assign configured = i_port_output_dir && i_port_pwm_function && !i_port_latch_high
                        && !i_long_mode;

    always_comb begin
        n_reload  = r_reload;
        n_compare = r_compare;
        n_period  = r_period;
        n_pulse   = r_pulse;
        n_active  = r_active;
        do_set    = 1'b0;
        do_play   = 1'b0;
        sp        = STOP_PERIOD;
        sq        = STOP_PULSE;
        flat      = 1'b0;
        cnt       = 2'd0;
        codes     = '0;
        case (i_kind)
            KIND_TONE_REG, KIND_OTHER_REG: begin
                if (!i_timer_low_running) begin
                    n_reload  = i_reload_value;
                    n_compare = i_compare_value;
                end
                if (!configured || !i_timer_low_running) begin
                    do_set = r_active;
                end else begin
                    do_set  = (i_kind == KIND_OTHER_REG);
                    sp      = PERIOD_FULL - {1'b0, n_reload};
                    sq      = n_compare - n_reload;
                    do_play = 1'b1;
                end
            end
            KIND_OVERFLOW: begin
                n_reload = i_reload_value;
                if (i_compare_reload_enable) begin
                    n_compare = i_compare_value;
                end
                do_set = configured;
                sp     = PERIOD_FULL - {1'b0, n_reload};
                sq     = n_compare - n_reload;
            end
            default: begin
            end
        endcase
        // tone change
        if (do_set && r_buzzer_en) begin
            if (sp < {1'b0, sq}) begin
                sp = {1'b0, sq};
            end
            if (!(sp == r_period && sq == r_pulse)) begin
                n_period = sp;
                n_pulse  = sq;
                flat     = (sq == 8'd0) || (sp == {1'b0, sq});
                if (r_active) begin
                    codes[cnt] = EV_STOP;
                    cnt        = cnt + 2'd1;
                end
                codes[cnt] = EV_UPDATE;
                cnt        = cnt + 2'd1;
                if (r_active) begin
                    if (flat) begin
                        n_active = 1'b0;
                    end else begin
                        codes[cnt] = EV_START;
                        cnt        = cnt + 2'd1;
                    end
                end
            end
        end
        // start request
        if (do_play && r_buzzer_en && !n_active) begin
            codes[cnt] = EV_START;
            cnt        = cnt + 2'd1;
            n_active   = 1'b1;
        end
    end

    assign o_push       = i_take && (cnt != 2'd0);
    assign o_job.count  = cnt;
    assign o_job.codes  = codes;
    assign o_job.period = n_period;
    assign o_job.pulse  = n_pulse;
    assign o_job.gain   = gain_of(r_resp_en, n_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buzzer_en <= 1'b1;
            r_resp_en   <= 1'b0;
            r_reload    <= '0;
            r_compare   <= '0;
            r_period    <= '0;
            r_pulse     <= '0;
            r_active    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_BUZZER_EN) begin
                    r_buzzer_en <= i_cfg_data;
                end else begin
                    r_resp_en <= i_cfg_data;
                end
            end
            if (i_take) begin
                r_reload  <= n_reload;
                r_compare <= n_compare;
                r_period  <= n_period;
                r_pulse   <= n_pulse;
                r_active  <= n_active;
            end
        end
    end

endmodule

// File: rtl/pbt_queue.sv
module pbt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pbt_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output pbt_pkg::t_job o_head
);
    import pbt_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

// File: rtl/pbt_back.sv
module pbt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  pbt_pkg::t_job i_head,
    output logic          o_pop,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [1:0]    o_event_code,
    output logic [8:0]    o_tone_period_out,
    output logic [7:0]    o_inverse_pulse_out,
    output logic [6:0]    o_gain_code,
    output logic          o_last_flag
);
    import pbt_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx, r_code;
    logic [8:0] r_period;
    logic [7:0] r_pulse;
    logic [6:0] r_gain;
    logic       r_last;
    logic       emit, last;

    assign emit  = !i_empty && (!r_valid || i_out_ready);
    assign last  = (r_idx == i_head.count - 2'd1);
    assign o_pop = emit && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_code   <= i_head.codes[r_idx];
            r_period <= i_head.period;
            r_pulse  <= i_head.pulse;
            r_gain   <= i_head.gain;
            r_last   <= last;
        end
    end

    assign o_out_valid         = r_valid;
    assign o_event_code        = r_code;
    assign o_tone_period_out   = r_period;
    assign o_inverse_pulse_out = r_pulse;
    assign o_gain_code         = r_gain;
    assign o_last_flag         = r_last;

endmodule

// File: rtl/pwm_buzzer_tone_controller.sv
// Buzzer tone controller. One register or overflow item is accepted per clock
// while the four-entry event queue has room; the front updates the tone state in
// the accept cycle and queues the item's events (zero to three). The back sends
// one event per clock from its output register while the output is ready, so an
// item with n events takes n output transfers (three at most); the first event
// passes through the queue and then the output register. Configuration writes
// are always ready and take effect on the next item.
module pwm_buzzer_tone_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_reload_value,
    input  logic [7:0] i_compare_value,
    input  logic       i_timer_low_running,
    input  logic       i_compare_reload_enable,
    input  logic       i_long_mode,
    input  logic       i_port_output_dir,
    input  logic       i_port_pwm_function,
    input  logic       i_port_latch_high,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_event_code,
    output logic [8:0] o_tone_period_out,
    output logic [7:0] o_inverse_pulse_out,
    output logic [6:0] o_gain_code,
    output logic       o_last_flag
);
    import pbt_pkg::*;

    logic w_push, w_full, w_pop, w_empty, w_take;
    t_job w_job, w_head;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !w_full;
    assign w_take      = i_in_valid && !w_full;

    pbt_front u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_take                 (w_take),
        .i_kind                 (i_kind),
        .i_reload_value         (i_reload_value),
        .i_compare_value        (i_compare_value),
        .i_timer_low_running    (i_timer_low_running),
        .i_compare_reload_enable(i_compare_reload_enable),
        .i_long_mode            (i_long_mode),
        .i_port_output_dir      (i_port_output_dir),
        .i_port_pwm_function    (i_port_pwm_function),
        .i_port_latch_high      (i_port_latch_high),
        .o_push                 (w_push),
        .o_job                  (w_job)
    );

    pbt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_head (w_head)
    );

    pbt_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (w_empty),
        .i_head             (w_head),
        .o_pop              (w_pop),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_event_code       (o_event_code),
        .o_tone_period_out  (o_tone_period_out),
        .o_inverse_pulse_out(o_inverse_pulse_out),
        .o_gain_code        (o_gain_code),
        .o_last_flag        (o_last_flag)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("event queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty) else $error("event queue underflow");

    a_stop_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_code == EV_STOP) |-> !o_last_flag)
        else $error("stop event ends an item");

endmodule
